// File: rtl/hidx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hidx_pkg;

  // Fixed field widths of the channels.
  localparam int CITE_W = 24;
  localparam int OUT_W  = 11;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic bin_rd;     // Read the bin of the accepted citation count.
    logic bin_inc;    // Write back the bin count plus one.
    logic drop;       // The accepted publication is beyond the limit.
    logic walk_init;  // Start a downward walk from the top bin.
    logic walk_zero;  // The walk serves an empty author: result is zero.
    logic walk_step;  // Issue the read of the current walk bin.
    logic res_load;   // Load the result into the output register.
    logic clr;        // Clear the publication count and the drop flag.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic room;       // Fewer than the maximum publications are binned.
    logic b_zero;     // The walk pointer sits at bin zero.
    logic out_free;   // The output register can take a result.
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/hidx_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one citation count per transfer.
interface hidx_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] citation_count;
  logic        last;
  logic        is_empty_author;

  modport source (output valid, output citation_count, output last,
                  output is_empty_author, input ready);
  modport sink   (input valid, input citation_count, input last,
                  input is_empty_author, output ready);
endinterface

// Result channel: one h-index per author.
interface hidx_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] h_index;
  logic [10:0] publication_total;
  logic        overflow;

  modport source (output valid, output h_index, output publication_total,
                  output overflow, input ready);
  modport sink   (input valid, input h_index, input publication_total,
                  input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/hidx_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hidx_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/hidx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hidx_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last,
  input  wire logic           in_is_empty_author,
  output logic                in_ready,
  input  wire hidx_pkg::sts_t sts,
  output hidx_pkg::cmd_t      cmd
);

  import hidx_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_UPD   = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   emit_r, emit_nxt;
  logic   xfer;

  assign in_ready = (state_r == S_IDLE);
  assign xfer     = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        // Clearing pass after reset; it produces no result.
        cmd.walk_init = 1'b1;
        emit_nxt      = 1'b0;
        state_nxt     = S_WALK;
      end
      S_IDLE: begin
        if (xfer) begin
          if (in_is_empty_author) begin
            cmd.walk_init = 1'b1;
            cmd.walk_zero = 1'b1;
            emit_nxt      = 1'b1;
            state_nxt     = S_WALK;
          end else if (sts.room) begin
            cmd.bin_rd = 1'b1;
            last_nxt   = in_last;
            state_nxt  = S_UPD;
          end else begin
            cmd.drop = 1'b1;
            if (in_last) begin
              cmd.walk_init = 1'b1;
              emit_nxt      = 1'b1;
              state_nxt     = S_WALK;
            end
          end
        end
      end
      S_UPD: begin
        cmd.bin_inc = 1'b1;
        if (last_r) begin
          cmd.walk_init = 1'b1;
          emit_nxt      = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.b_zero) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!emit_r) begin
          cmd.clr   = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.res_load = 1'b1;
          cmd.clr      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      last_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      emit_r  <= emit_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hidx_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hidx_dp #(
  parameter int MAX_PUBS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire hidx_pkg::cmd_t               cmd,
  output hidx_pkg::sts_t                    sts,
  input  wire logic [hidx_pkg::CITE_W-1:0]  in_citation_count,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [hidx_pkg::OUT_W-1:0]   out_h_index,
  output logic      [hidx_pkg::OUT_W-1:0]   out_publication_total,
  output logic                              out_overflow
);

  import hidx_pkg::*;

  localparam int                CNT_W    = $clog2(MAX_PUBS + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_PUBS);
  localparam logic [CITE_W-1:0] MAX_CITE = CITE_W'(MAX_PUBS);

  logic [CNT_W-1:0] items_r;
  logic             drop_r;
  logic [CNT_W-1:0] upd_addr_r;
  logic [CNT_W-1:0] b_r;
  logic [CNT_W-1:0] wb_addr_r;
  logic             wb_vld_r;
  logic [CNT_W-1:0] cum_r, cum_nxt;
  logic [CNT_W-1:0] h_r;
  logic             found_r;
  logic             zero_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_h_r, out_tot_r;
  logic             out_ovf_r;

  logic [CNT_W-1:0] bin;
  logic             ram_we, ram_re;
  logic [CNT_W-1:0] ram_waddr, ram_raddr, ram_wdata, ram_rdata;
  logic             hit;

  // Clamp the citation count to the top bin.
  assign bin = (in_citation_count > MAX_CITE) ? MAX_CNT : in_citation_count[CNT_W-1:0];

  // Memory port selection: histogram update or walk with clear-behind.
  always_comb begin
    ram_re    = cmd.bin_rd || cmd.walk_step;
    ram_raddr = cmd.bin_rd ? bin : b_r;
    ram_we    = cmd.bin_inc || wb_vld_r;
    ram_waddr = cmd.bin_inc ? upd_addr_r : wb_addr_r;
    ram_wdata = cmd.bin_inc ? (ram_rdata + CNT_W'(1)) : '0;
  end

  hidx_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_PUBS + 1)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Running sum over the bins and the first bin that satisfies the h rule.
  assign cum_nxt = cum_r + ram_rdata;
  assign hit     = wb_vld_r && !found_r && (wb_addr_r <= items_r) && (cum_nxt >= wb_addr_r);

  // Per-author count and drop flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      items_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.clr) begin
      items_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      if (cmd.bin_inc) begin
        items_r <= items_r + CNT_W'(1);
      end
      if (cmd.drop) begin
        drop_r <= 1'b1;
      end
    end
  end

  // Walk pointer and read pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else begin
      wb_vld_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_rd) begin
      upd_addr_r <= bin;
    end
    if (cmd.walk_init) begin
      b_r     <= MAX_CNT;
      cum_r   <= '0;
      found_r <= 1'b0;
      zero_r  <= cmd.walk_zero;
    end else begin
      if (cmd.walk_step && (b_r != '0)) begin
        b_r <= b_r - CNT_W'(1);
      end
      if (wb_vld_r) begin
        cum_r <= cum_nxt;
      end
      if (hit) begin
        found_r <= 1'b1;
        h_r     <= wb_addr_r;
      end
    end
    if (cmd.walk_step) begin
      wb_addr_r <= b_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_h_r   <= zero_r ? '0 : OUT_W'(h_r);
      out_tot_r <= zero_r ? '0 : OUT_W'(items_r);
      out_ovf_r <= zero_r ? 1'b0 : drop_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_h_index           = out_h_r;
  assign out_publication_total = out_tot_r;
  assign out_overflow          = out_ovf_r;

  assign sts.room     = (items_r < MAX_CNT);
  assign sts.b_zero   = (b_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // A result is only loaded after the walk has found its bin.
  a_found_at_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> found_r)
    else $error("result loaded before the walk found h");

  // The histogram update and the walk never share the write port.
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.bin_inc && wb_vld_r))
    else $error("histogram increment collides with walk clear");

  // The publication count stays within the limit.
  a_items_bound: assert property (@(posedge clk) disable iff (!rst_n)
    items_r <= MAX_CNT)
    else $error("publication count beyond the limit");

  // A loaded result is offered on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not offered");

endmodule

`default_nettype wire

// File: rtl/h_index_from_citation_counts_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// h-index unit. Each transfer on the input channel brings the citation count
// of one publication; the count, clamped to MAX_PUBS, is counted into a
// histogram held in a single memory of MAX_PUBS+1 bins. A binned publication
// takes one read and one write of its bin; a publication beyond MAX_PUBS is
// dropped and sets the overflow flag. On the item marked last, or on an
// empty-author item, the unit walks all MAX_PUBS+1 bins downward with a
// running sum, one bin per cycle, and clears each bin behind the walk. The
// next item is taken only once the author is closed; closing is held while
// the previous result still waits in the output register, since a new
// result is loaded only once that register is free. After reset the same
// walk clears the memory, and no item is accepted until that walk ends.
module h_index_from_citation_counts_unit #(
  parameter int MAX_PUBS = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hidx_in_if.sink     in_ch,
  hidx_out_if.source  out_ch
);

  import hidx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Control sequencing of binning, walk and result.
  hidx_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_ch.valid),
    .in_last            (in_ch.last),
    .in_is_empty_author (in_ch.is_empty_author),
    .in_ready           (in_ch.ready),
    .sts                (sts),
    .cmd                (cmd)
  );

  // Histogram, counters, walk and output register.
  hidx_dp #(
    .MAX_PUBS (MAX_PUBS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_citation_count     (in_ch.citation_count),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_h_index           (out_ch.h_index),
    .out_publication_total (out_ch.publication_total),
    .out_overflow          (out_ch.overflow)
  );

endmodule

`default_nettype wire
